/* sv/rks_pkg.sv */
package rks_pkg;

   localparam int KEY_W = 32;
   localparam int ROW_W = 16;

   typedef logic signed [KEY_W-1:0] key_type;
   typedef logic [ROW_W-1:0]        row_type;

endpackage

/* sv/rks_store.sv */
module rks_store #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  rks_pkg::key_type  wr_key,
   input  logic [AW-1:0]     wr_pos,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output rks_pkg::key_type  rd_key,
   output logic [AW-1:0]     rd_pos
);
   import rks_pkg::*;

   localparam int EW = KEY_W + AW;

   logic [EW-1:0] mem [DEPTH];
   logic [EW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_key, wr_pos};
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_key = key_type'(rd_data_ff[EW-1:AW]);
   assign rd_pos = rd_data_ff[AW-1:0];

endmodule

/* sv/rks_seq.sv */
module rks_seq #(
   parameter int DEPTH = 64,
   parameter int AW    = 6,
   parameter int CW    = 7
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rks_pkg::key_type  req_key,
   input  logic              req_last_item,
   input  rks_pkg::row_type  row_base,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rks_pkg::row_type  rsp_source_row,
   output rks_pkg::key_type  rsp_sorted_key,
   output logic              rsp_dropped,
   output logic              rsp_last_result,
   output logic              wr_en,
   output logic [AW-1:0]     wr_addr,
   output rks_pkg::key_type  wr_key,
   output logic [AW-1:0]     wr_pos,
   output logic              rd_en,
   output logic [AW-1:0]     rd_addr,
   input  rks_pkg::key_type  rd_key,
   input  logic [AW-1:0]     rd_pos
);
   import rks_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_CMP,
      S_INS_LOW,
      S_EMIT_RD,
      S_EMIT_LD
   } state_type;

   localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
   localparam logic [CW-1:0] CNT_ONE  = CW'(1);

   state_type       state_ff;
   logic [CW-1:0]   count_ff;
   logic            ovf_ff;
   logic [CW-1:0]   idx_ff;
   key_type         key_ff;
   logic            last_ff;
   logic [CW-1:0]   emit_ff;
   logic            rsp_valid_ff;
   row_type         rsp_row_ff;
   key_type         rsp_key_ff;
   logic            rsp_drop_ff;
   logic            rsp_last_ff;

   logic            accept;
   logic            shift_up;
   logic            out_free;
   logic            rsp_load;
   logic [CW-1:0]   idx_dec;
   logic [CW-1:0]   idx_dec2;
   logic [CW-1:0]   cnt_dec;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign shift_up  = (rd_key > key_ff);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_load  = (state_ff == S_EMIT_LD) && out_free;
   assign idx_dec   = idx_ff - CNT_ONE;
   assign idx_dec2  = idx_ff - CW'(2);
   assign cnt_dec   = count_ff - CNT_ONE;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff[AW-1:0];
      wr_key  = key_ff;
      wr_pos  = count_ff[AW-1:0];
      rd_en   = 1'b0;
      rd_addr = emit_ff[AW-1:0];
      case (state_ff)
         S_IDLE: begin
            if (accept && (count_ff != CNT_FULL)) begin
               if (count_ff == '0) begin
                  wr_en   = 1'b1;
                  wr_addr = '0;
                  wr_key  = req_key;
                  wr_pos  = '0;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = cnt_dec[AW-1:0];
               end
            end
         end
         S_INS_CMP: begin
            wr_en = 1'b1;
            if (shift_up) begin
               wr_key = rd_key;
               wr_pos = rd_pos;
               if (idx_ff > CNT_ONE) begin
                  rd_en   = 1'b1;
                  rd_addr = idx_dec2[AW-1:0];
               end
            end
         end
         S_INS_LOW: begin
            wr_en   = 1'b1;
            wr_addr = '0;
         end
         S_EMIT_RD: begin
            rd_en = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         emit_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  key_ff  <= req_key;
                  last_ff <= req_last_item;
                  idx_ff  <= count_ff;
                  emit_ff <= '0;
                  if (count_ff == CNT_FULL) begin
                     ovf_ff   <= 1'b1;
                     state_ff <= req_last_item ? S_EMIT_RD : S_IDLE;
                  end else if (count_ff == '0) begin
                     count_ff <= CNT_ONE;
                     state_ff <= req_last_item ? S_EMIT_RD : S_IDLE;
                  end else begin
                     state_ff <= S_INS_CMP;
                  end
               end
            end
            S_INS_CMP: begin
               if (shift_up) begin
                  idx_ff <= idx_dec;
                  if (idx_ff <= CNT_ONE) begin
                     state_ff <= S_INS_LOW;
                  end
               end else begin
                  count_ff <= count_ff + CNT_ONE;
                  state_ff <= last_ff ? S_EMIT_RD : S_IDLE;
               end
            end
            S_INS_LOW: begin
               count_ff <= count_ff + CNT_ONE;
               state_ff <= last_ff ? S_EMIT_RD : S_IDLE;
            end
            S_EMIT_RD: begin
               state_ff <= S_EMIT_LD;
            end
            S_EMIT_LD: begin
               if (out_free) begin
                  rsp_row_ff   <= row_base + ROW_W'(rd_pos);
                  rsp_key_ff   <= rd_key;
                  rsp_drop_ff  <= ovf_ff;
                  rsp_last_ff  <= (emit_ff == cnt_dec);
                  if (emit_ff == cnt_dec) begin
                     count_ff <= '0;
                     ovf_ff   <= 1'b0;
                     state_ff <= S_IDLE;
                  end else begin
                     emit_ff  <= emit_ff + CNT_ONE;
                     state_ff <= S_EMIT_RD;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_source_row  = rsp_row_ff;
   assign rsp_sorted_key  = rsp_key_ff;
   assign rsp_dropped     = rsp_drop_ff;
   assign rsp_last_result = rsp_last_ff;

endmodule

/* sv/row_key_sorter_unit.sv */
// Stable key sorter. Each accepted word carries one signed Q16.16 key; keys are
// inserted into a sorted single-port-write, single-port-read memory by shifting
// larger entries up one slot per cycle. Equal keys keep load order. A word with
// last_item set finishes its insertion and then emits every stored key in
// ascending order, each result word by a memory read and then the output register,
// with source_row = row base register + load position (mod 65536) and last_result
// on the final word. Keys past DEPTH are discarded and flagged on every result of
// that run as dropped. req_stall is high whenever an insertion or emission is in
// progress; the row base register is sampled at emission.
module row_key_sorter_unit #(
   parameter int DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  rks_pkg::row_type  csr_wr_data,
   input  logic              req_valid,
   output logic              req_stall,
   input  rks_pkg::key_type  req_key,
   input  logic              req_last_item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rks_pkg::row_type  rsp_source_row,
   output rks_pkg::key_type  rsp_sorted_key,
   output logic              rsp_dropped,
   output logic              rsp_last_result
);
   import rks_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   row_type        row_base_ff;
   logic           wr_en;
   logic [AW-1:0]  wr_addr;
   key_type        wr_key;
   logic [AW-1:0]  wr_pos;
   logic           rd_en;
   logic [AW-1:0]  rd_addr;
   key_type        rd_key;
   logic [AW-1:0]  rd_pos;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_base_ff <= '0;
      end else if (csr_wr_en) begin
         row_base_ff <= csr_wr_data;
      end
   end

   rks_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_key  (wr_key),
      .wr_pos  (wr_pos),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_key  (rd_key),
      .rd_pos  (rd_pos)
   );

   rks_seq #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .CW    (CW)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_key         (req_key),
      .req_last_item   (req_last_item),
      .row_base        (row_base_ff),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_source_row  (rsp_source_row),
      .rsp_sorted_key  (rsp_sorted_key),
      .rsp_dropped     (rsp_dropped),
      .rsp_last_result (rsp_last_result),
      .wr_en           (wr_en),
      .wr_addr         (wr_addr),
      .wr_key          (wr_key),
      .wr_pos          (wr_pos),
      .rd_en           (rd_en),
      .rd_addr         (rd_addr),
      .rd_key          (rd_key),
      .rd_pos          (rd_pos)
   );

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
   import rks_pkg::*;

   localparam int DEPTH = 64;

   typedef struct {
      row_type row;
      key_type key;
      logic    dropped;
      logic    fin;
   } row_word_type;

   class sorted_row_model;
      key_type      key_slots[DEPTH];
      logic [5:0]   load_pos[DEPTH];
      int           fill;
      bit           overflow;
      row_type      row_base;
      row_word_type expected_rows[$];
      int           mismatches;

      function void note_key(key_type k, logic fin);
         int i;
         if (fill >= DEPTH) begin
            overflow = 1'b1;
         end else begin
            i = fill;
            while (i > 0 && key_slots[i-1] > k) begin
               key_slots[i] = key_slots[i-1];
               load_pos[i]  = load_pos[i-1];
               i--;
            end
            key_slots[i] = k;
            load_pos[i]  = 6'(fill);
            fill++;
         end
         if (fin) begin
            for (int j = 0; j < fill; j++) begin
               expected_rows.push_back('{row_type'(row_base + load_pos[j]), key_slots[j],
                                         overflow, j == fill - 1});
            end
            fill     = 0;
            overflow = 1'b0;
         end
      endfunction

      function void check_word(row_type r, key_type k, logic d, logic l);
         row_word_type want;
         if (expected_rows.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: row %h key %h dropped %b last %b", r, k, d, l);
            return;
         end
         want = expected_rows.pop_front();
         if (want.row !== r || want.key !== k || want.dropped !== d || want.fin !== l) begin
            mismatches++;
            if (mismatches <= 10)
               $display("word mismatch: exp row %h key %h dropped %b last %b,",
                        want.row, want.key, want.dropped, want.fin,
                        " got row %h key %h dropped %b last %b", r, k, d, l);
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    csr_wr_en = 1'b0;
   row_type csr_wr_data = '0;
   logic    req_valid = 1'b0;
   logic    req_stall;
   key_type req_key = '0;
   logic    req_last_item = 1'b0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   row_type rsp_source_row;
   key_type rsp_sorted_key;
   logic    rsp_dropped;
   logic    rsp_last_result;

   sorted_row_model rows = new();
   int keys_sent;
   int quiet_left;
   int hold_left;

   row_key_sorter_unit #(.DEPTH(DEPTH)) dut (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_key        (req_key),
      .req_last_item  (req_last_item),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_source_row (rsp_source_row),
      .rsp_sorted_key (rsp_sorted_key),
      .rsp_dropped    (rsp_dropped),
      .rsp_last_result(rsp_last_result)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // receiver back-pressure: random toggling, long holds, and quiet stretches
   always @(posedge clock) begin
      if (quiet_left > 0) begin
         quiet_left--;
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case ($urandom_range(0, 19))
            0: begin
               hold_left = $urandom_range(10, 40);
               rsp_stall <= 1'b1;
            end
            1, 2: begin
               quiet_left = $urandom_range(30, 150);
               rsp_stall <= 1'b0;
            end
            default: rsp_stall <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         rows.check_word(rsp_source_row, rsp_sorted_key, rsp_dropped, rsp_last_result);
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic key_type random_key();
      case ($urandom_range(0, 3))
         0: begin
            case ($urandom_range(0, 4))
               0: return 32'sh8000_0000;
               1: return 32'sh7FFF_FFFF;
               2: return 32'sh0000_0000;
               3: return -32'sd1;
               default: return 32'sh0001_0000;
            endcase
         end
         1: return key_type'($signed($urandom_range(0, 8)) - 4);
         default: return key_type'($urandom);
      endcase
   endfunction

   task automatic send_key(input key_type k, input logic fin, input bit no_gaps);
      int gap;
      req_valid     <= 1'b1;
      req_key       <= k;
      req_last_item <= fin;
      do @(posedge clock); while (req_stall !== 1'b0);
      rows.note_key(k, fin);
      keys_sent++;
      gap = no_gaps ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_run(input int len);
      bit no_gaps;
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len; i++)
         send_key(random_key(), i == len - 1, no_gaps);
   endtask

   // hold the sender until every sorted word is out and the block has settled
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (rows.expected_rows.size() != 0) @(posedge clock);
      repeat (DEPTH + 8) @(posedge clock);
   endtask

   task automatic write_row_base(input row_type v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      rows.row_base = v;
   endtask

   initial begin
      #1000000;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      int phase;
      int runs;
      row_type base;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_row_base(16'h0000);
      send_key(32'sh0005_8000, 1'b1, 1'b0);
      send_key(32'sh7FFF_FFFF, 1'b0, 1'b0);
      send_key(32'sh8000_0000, 1'b0, 1'b0);
      send_key(32'sh0000_0000, 1'b0, 1'b1);
      send_key(-32'sd1, 1'b0, 1'b1);
      send_key(32'sh0000_0001, 1'b0, 1'b0);
      send_key(32'sh0000_0000, 1'b0, 1'b0);
      send_key(32'sh8000_0000, 1'b0, 1'b0);
      send_key(32'sh7FFF_FFFF, 1'b1, 1'b0);
      wait_idle();

      // row number wrap with ties and a reversed run
      write_row_base(16'hFFFF);
      send_key(32'sh0003_0000, 1'b0, 1'b0);
      send_key(32'sh0003_0000, 1'b0, 1'b0);
      send_key(32'sh0003_0000, 1'b0, 1'b0);
      send_key(32'sh0002_0000, 1'b1, 1'b0);
      for (int i = 10; i > 5; i--)
         send_key(key_type'(i), i == 6, 1'b1);
      wait_idle();
      write_row_base(16'hFFFC);
      send_run(6);
      wait_idle();

      // full store, then overflow including the closing key
      write_row_base(row_type'($urandom));
      send_run(DEPTH);
      send_run(DEPTH + 2);
      wait_idle();

      phase = 0;
      while (keys_sent < 260) begin
         case (phase % 4)
            0: base = 16'hFFFF;
            1: base = row_type'($urandom);
            2: base = 16'h0000;
            default: base = 16'hFFC0 + row_type'($urandom_range(0, 63));
         endcase
         write_row_base(base);
         runs = $urandom_range(2, 5);
         for (int r = 0; r < runs; r++) begin
            if ($urandom_range(0, 99) < 3)
               send_run($urandom_range(DEPTH - 4, DEPTH + 6));
            else
               send_run($urandom_range(1, 10));
            if ($urandom_range(0, 3) == 0)
               wait_idle();
         end
         wait_idle();
         phase++;
      end

      wait_idle();
      if (rows.mismatches == 0 && rows.expected_rows.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
